/* rtl/ubd_pkg.sv */
package ubd_pkg;

  typedef struct packed {
    logic room;
    logic completes_detect;
  } ubd_status_t;

  typedef struct packed {
    logic       take;
    logic       step;
    logic [1:0] idx;
    logic       flush;
  } ubd_cmd_t;

endpackage

/* rtl/unicode_bom_detect_decoder.sv */
// a code point completed by an input byte is registered in the result queue before it is offered
// throughput: one byte per cycle, stalled while the two-entry result queue is full or during replay and flush
// the fourth byte of a stream stalls input for four replay steps of the held
// bytes through the decoder and one flush of the held result
// rst is synchronous, active high; clears detection, decoder state and queue
module unicode_bom_detect_decoder
  import ubd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tuser,  // start_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // code_point, encoding_seen, zero fill
  output logic        m_axis_tlast   // last_of_run
);

  ubd_status_t status;
  ubd_cmd_t    cmd;
  logic [31:0] out_cp;
  logic [2:0]  out_enc;

  ubd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ubd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_axis_tdata),
    .in_start  (s_axis_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_cp    (out_cp),
    .out_enc   (out_enc),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_enc, out_cp};

endmodule

/* rtl/ubd_ctrl.sv */
module ubd_ctrl
  import ubd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ubd_status_t status,
  output ubd_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_REPLAY,
    ST_FLUSH
  } state_t;

  state_t     state;
  logic [1:0] idx;

  assign in_ready  = (state == ST_RUN) && status.room;
  assign cmd.take  = in_valid && in_ready;
  assign cmd.step  = (state == ST_REPLAY) && status.room;
  assign cmd.idx   = idx;
  assign cmd.flush = (state == ST_FLUSH) && status.room;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      idx   <= 2'd0;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (cmd.take && status.completes_detect) begin
            state <= ST_REPLAY;
            idx   <= 2'd0;
          end
        end
        ST_REPLAY: begin
          if (status.room) begin
            if (idx == 2'd3) begin
              state <= ST_FLUSH;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        ST_FLUSH: begin
          if (status.room) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule

/* rtl/ubd_datapath.sv */
module ubd_datapath
  import ubd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  in_byte,
  input  logic        in_start,
  input  ubd_cmd_t    cmd,
  output ubd_status_t status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_cp,
  output logic [2:0]  out_enc,
  output logic        out_last
);

  typedef enum logic [2:0] {
    ENC_UTF8    = 3'd0,
    ENC_UTF16BE = 3'd1,
    ENC_UTF16LE = 3'd2,
    ENC_UTF32BE = 3'd3,
    ENC_UTF32LE = 3'd4
  } enc_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [1:0]  rem;
    logic [1:0]  idx;
    logic        hsp;
  } dec_state_t;

  typedef struct packed {
    dec_state_t  st;
    logic        emit;
    logic [31:0] cp;
  } dec_res_t;

  typedef struct packed {
    logic [31:0] cp;
    logic [2:0]  enc;
    logic        last;
  } out_item_t;

  localparam logic [31:0] LowSurrBase = 32'h0000_DC00;
  localparam logic [31:0] SuppBase    = 32'h0001_0000;
  localparam dec_state_t  DecClear    = '0;

  function automatic enc_t choose_enc(logic [7:0] b0, logic [7:0] b1,
                                      logic [7:0] b2, logic [7:0] b3);
    enc_t e;
    if (b0 == 8'h00 && b1 == 8'h00 && b2 == 8'hfe && b3 == 8'hff) begin
      e = ENC_UTF32BE;
    end else if (b0 == 8'hff && b1 == 8'hfe) begin
      e = (b2 == 8'h00 && b3 == 8'h00) ? ENC_UTF32LE : ENC_UTF16LE;
    end else if (b0 == 8'hfe && b1 == 8'hff) begin
      e = ENC_UTF16BE;
    end else begin
      e = ENC_UTF8;
    end
    return e;
  endfunction

  function automatic dec_res_t feed(dec_state_t st, logic [7:0] b, enc_t mode);
    dec_res_t    r;
    logic [15:0] unit;
    logic [31:0] diff;
    logic [31:0] base;
    logic        big;
    r      = '0;
    r.st   = st;
    unit   = '0;
    diff   = '0;
    base   = '0;
    big    = 1'b0;
    unique case (mode)
      ENC_UTF16BE, ENC_UTF16LE: begin
        big = (mode == ENC_UTF16BE);
        if (st.idx == 2'd0) begin
          r.st.acc = {st.acc[31:16], 8'h00, b};
          r.st.idx = 2'd1;
        end else begin
          r.st.idx = 2'd0;
          unit = big ? {st.acc[7:0], b} : {b, st.acc[7:0]};
          if (st.hsp) begin
            r.st.hsp = 1'b0;
            r.st.acc = '0;
            diff     = {16'h0000, unit} - LowSurrBase;
            r.cp     = ({11'b0, st.acc[26:16], 10'b0} | diff) + SuppBase;
            r.emit   = 1'b1;
          end else if (unit[15:11] == 5'b11011) begin
            r.st.hsp = 1'b1;
            r.st.acc = {5'b0, unit[10:0], 16'h0000};
          end else begin
            r.cp   = {16'h0000, unit};
            r.emit = 1'b1;
          end
        end
      end
      ENC_UTF32BE, ENC_UTF32LE: begin
        base = (st.idx == 2'd0) ? 32'h0 : st.acc;
        if (mode == ENC_UTF32BE) begin
          r.st.acc = {base[23:0], b};
        end else begin
          r.st.acc = {b, base[31:8]};
        end
        r.st.idx = st.idx + 2'd1;
        r.emit   = (st.idx == 2'd3);
        r.cp     = r.st.acc;
      end
      default: begin
        if (st.rem != 2'd0) begin
          r.st.acc = {st.acc[25:0], b[5:0]};
          r.st.rem = st.rem - 2'd1;
          r.emit   = (st.rem == 2'd1);
          r.cp     = r.st.acc;
        end else if (b[7] == 1'b0) begin
          r.cp   = {24'h0, b};
          r.emit = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          r.st.acc = {27'h0, b[4:0]};
          r.st.rem = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          r.st.acc = {28'h0, b[3:0]};
          r.st.rem = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          r.st.acc = {29'h0, b[2:0]};
          r.st.rem = 2'd3;
        end else begin
          r.cp   = '0;
          r.emit = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  logic [2:0]  detect_count;
  logic [7:0]  lookahead [4];
  enc_t        mode;
  dec_state_t  dec;
  logic [31:0] hold_cp;
  logic        hold_valid;

  out_item_t   fifo [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fifo_count;

  logic [2:0]  cnt_eff;
  dec_state_t  dec_eff;
  dec_res_t    run_res;
  dec_res_t    rep_res;
  logic        push;
  out_item_t   push_item;
  logic        pop;

  assign cnt_eff = in_start ? 3'd0 : detect_count;
  assign dec_eff = in_start ? DecClear : dec;
  assign run_res = feed(dec_eff, in_byte, mode);
  assign rep_res = feed(dec, lookahead[cmd.idx], mode);

  assign status.room             = (fifo_count != 2'd2);
  assign status.completes_detect = (cnt_eff == 3'd3);

  always_comb begin
    push      = 1'b0;
    push_item = '{cp: run_res.cp, enc: mode, last: 1'b1};
    if (cmd.take) begin
      push = (cnt_eff == 3'd4) && run_res.emit;
    end else if (cmd.step) begin
      push      = hold_valid && rep_res.emit;
      push_item = '{cp: hold_cp, enc: mode, last: 1'b0};
    end else if (cmd.flush) begin
      push      = hold_valid;
      push_item = '{cp: hold_cp, enc: mode, last: 1'b1};
    end
  end

  assign pop       = out_valid && out_ready;
  assign out_valid = (fifo_count != 2'd0);
  assign out_cp    = fifo[rd_ptr].cp;
  assign out_enc   = fifo[rd_ptr].enc;
  assign out_last  = fifo[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_count <= 3'd0;
      mode         <= ENC_UTF8;
      dec          <= DecClear;
      hold_valid   <= 1'b0;
    end else if (cmd.take) begin
      if (cnt_eff != 3'd4) begin
        detect_count <= cnt_eff + 3'd1;
        if (cnt_eff == 3'd3) begin
          mode       <= choose_enc(lookahead[0], lookahead[1], lookahead[2], in_byte);
          dec        <= DecClear;
          hold_valid <= 1'b0;
        end else begin
          dec <= dec_eff;
        end
      end else begin
        dec <= run_res.st;
      end
    end else if (cmd.step) begin
      dec <= rep_res.st;
      if (rep_res.emit) begin
        hold_valid <= 1'b1;
      end
    end else if (cmd.flush) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && cnt_eff != 3'd4) begin
      lookahead[cnt_eff[1:0]] <= in_byte;
    end
    if (cmd.step && rep_res.emit) begin
      hold_cp <= rep_res.cp;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      fifo_count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fifo_count <= fifo_count + 2'd1;
        2'b01:   fifo_count <= fifo_count - 2'd1;
        default: fifo_count <= fifo_count;
      endcase
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;

  localparam logic [2:0] ENC_UTF8    = 3'd0;
  localparam logic [2:0] ENC_UTF16BE = 3'd1;
  localparam logic [2:0] ENC_UTF16LE = 3'd2;
  localparam logic [2:0] ENC_UTF32BE = 3'd3;
  localparam logic [2:0] ENC_UTF32LE = 3'd4;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 128;
  localparam int LONG_HOLD      = 200;

  typedef struct {
    logic [7:0] data;
    logic       sos;
    bit         drain;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] cp;
    logic [2:0]  enc;
    logic        last;
  } cp_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // data_byte
  logic        s_axis_tuser = 1'b0;   // start_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;          // code_point, encoding_seen, zero fill
  logic        m_axis_tlast;          // last_of_run

  byte_item_t byte_q[$];
  cp_rec_t    expected_cps[$];

  int mismatches  = 0;
  int bytes_taken = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int hold_left   = 0;
  int rx_phase    = 0;
  bit held_once   = 1'b0;
  bit in_hs       = 1'b0;
  bit drain_next  = 1'b0;
  bit sos_next    = 1'b0;

  // decoder state mirror
  logic [2:0]  det_cnt   = 3'd0;
  logic [7:0]  held [4];
  logic [2:0]  enc_mode  = ENC_UTF8;
  logic [31:0] acc       = 32'h0;
  logic [1:0]  cont_left = 2'd0;
  logic [1:0]  unit_idx  = 2'd0;
  logic        sur_pend  = 1'b0;

  always #5 clk = ~clk;

  unicode_bom_detect_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic void clear_decoder();
    acc = 32'h0;
    cont_left = 2'd0;
    unit_idx = 2'd0;
    sur_pend = 1'b0;
  endfunction

  function automatic logic [2:0] choose_encoding();
    if (held[0] == 8'h00 && held[1] == 8'h00 && held[2] == 8'hFE && held[3] == 8'hFF)
      return ENC_UTF32BE;
    if (held[0] == 8'hFF && held[1] == 8'hFE)
      return (held[2] == 8'h00 && held[3] == 8'h00) ? ENC_UTF32LE : ENC_UTF16LE;
    if (held[0] == 8'hFE && held[1] == 8'hFF)
      return ENC_UTF16BE;
    return ENC_UTF8;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output logic [31:0] cp);
    logic [31:0] unit;
    cp = 32'h0;
    case (enc_mode)
      ENC_UTF16BE, ENC_UTF16LE: begin
        if (unit_idx == 2'd0) begin
          acc = {acc[31:16], 8'h00, b};
          unit_idx = 2'd1;
          return 1'b0;
        end
        unit_idx = 2'd0;
        unit = (enc_mode == ENC_UTF16BE) ? {16'h0, acc[7:0], b} : {16'h0, b, acc[7:0]};
        if (sur_pend) begin
          // pair combine, wraps for a trailing unit below DC00
          cp = ({11'h0, acc[26:16], 10'h0} | (unit - 32'hDC00)) + 32'h10000;
          sur_pend = 1'b0;
          acc = 32'h0;
          return 1'b1;
        end
        if (unit >= 32'hD800 && unit <= 32'hDFFF) begin
          sur_pend = 1'b1;
          acc = (unit - 32'hD800) << 16;
          return 1'b0;
        end
        cp = unit;
        return 1'b1;
      end
      ENC_UTF32BE, ENC_UTF32LE: begin
        if (unit_idx == 2'd0)
          acc = 32'h0;
        acc = (enc_mode == ENC_UTF32BE) ? {acc[23:0], b} : {b, acc[31:8]};
        unit_idx = unit_idx + 2'd1;
        cp = acc;
        return unit_idx == 2'd0;
      end
      default: begin
        if (cont_left != 2'd0) begin
          acc = {acc[25:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          cp = acc;
          return cont_left == 2'd0;
        end
        if (b <= 8'h7F) begin
          cp = {24'h0, b};
          return 1'b1;
        end
        if (b >= 8'hC0 && b <= 8'hDF) begin
          acc = {27'h0, b[4:0]};
          cont_left = 2'd1;
          return 1'b0;
        end
        if (b >= 8'hE0 && b <= 8'hEF) begin
          acc = {28'h0, b[3:0]};
          cont_left = 2'd2;
          return 1'b0;
        end
        if (b >= 8'hF0 && b <= 8'hF7) begin
          acc = {29'h0, b[2:0]};
          cont_left = 2'd3;
          return 1'b0;
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic sos);
    cp_rec_t     found [4];
    int          n = 0;
    logic [31:0] cp;
    if (sos) begin
      det_cnt = 3'd0;
      clear_decoder();
    end
    if (det_cnt < 3'd4) begin
      held[det_cnt[1:0]] = b;
      det_cnt = det_cnt + 3'd1;
      if (det_cnt == 3'd4) begin
        enc_mode = choose_encoding();
        clear_decoder();
        // held bytes replayed, mark included
        for (int i = 0; i < 4; i++) begin
          if (decode_byte(held[i], cp)) begin
            found[n] = '{cp: cp, enc: enc_mode, last: 1'b0};
            n++;
          end
        end
      end
    end else if (decode_byte(b, cp)) begin
      found[0] = '{cp: cp, enc: enc_mode, last: 1'b0};
      n = 1;
    end
    for (int i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      expected_cps.push_back(found[i]);
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    byte_item_t it;
    it.data = b;
    it.sos = sos_next;
    it.drain = drain_next;
    sos_next = 1'b0;
    drain_next = 1'b0;
    byte_q.push_back(it);
  endtask

  task automatic queue_word(input logic [31:0] w);
    queue_byte(w[31:24]);
    queue_byte(w[23:16]);
    queue_byte(w[15:8]);
    queue_byte(w[7:0]);
  endtask

  task automatic queue_word32(input logic [31:0] w, input bit big);
    if (big)
      queue_word(w);
    else
      queue_word({w[7:0], w[15:8], w[23:16], w[31:24]});
  endtask

  task automatic queue_unit16(input logic [15:0] u, input bit big);
    if (big) begin
      queue_byte(u[15:8]);
      queue_byte(u[7:0]);
    end else begin
      queue_byte(u[7:0]);
      queue_byte(u[15:8]);
    end
  endtask

  task automatic queue_utf16(input logic [31:0] cp, input bit big);
    logic [31:0] v;
    if (cp < 32'h10000) begin
      queue_unit16(cp[15:0], big);
    end else begin
      v = cp - 32'h10000;
      queue_unit16(16'hD800 | {6'h0, v[19:10]}, big);
      queue_unit16(16'hDC00 | {6'h0, v[9:0]}, big);
    end
  endtask

  task automatic queue_utf8(input logic [31:0] cp);
    if (cp < 32'h80) begin
      queue_byte(cp[7:0]);
    end else if (cp < 32'h800) begin
      queue_byte({3'b110, cp[10:6]});
      queue_byte({2'b10, cp[5:0]});
    end else if (cp < 32'h10000) begin
      queue_byte({4'b1110, cp[15:12]});
      queue_byte({2'b10, cp[11:6]});
      queue_byte({2'b10, cp[5:0]});
    end else begin
      queue_byte({5'b11110, cp[20:18]});
      queue_byte({2'b10, cp[17:12]});
      queue_byte({2'b10, cp[11:6]});
      queue_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic queue_stream();
    int          kind;
    int          n_cps;
    int          cls;
    logic [31:0] cp;
    kind = $urandom_range(0, 9);
    n_cps = $urandom_range(1, 8);
    sos_next = 1'b1;
    case (kind)
      0, 1: begin
        queue_byte(8'hEF);
        queue_byte(8'hBB);
        queue_byte(8'hBF);
      end
      4, 5: begin
        queue_byte(8'hFE);
        queue_byte(8'hFF);
      end
      6: begin
        queue_byte(8'hFF);
        queue_byte(8'hFE);
      end
      7: queue_word(32'h0000FEFF);
      8: queue_word(32'hFFFE0000);
      default: ;
    endcase
    if (kind == 9) begin
      // short stream, cut off by the next restart
      repeat ($urandom_range(1, 3)) queue_byte($urandom_range(0, 255));
    end else begin
      repeat (n_cps) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_byte($urandom_range(0, 255));
        end else if (kind <= 3) begin
          cls = $urandom_range(0, 3);
          cp = (cls == 0) ? $urandom_range(0, 32'h7F) :
               (cls == 1) ? $urandom_range(32'h80, 32'h7FF) :
               (cls == 2) ? $urandom_range(32'h800, 32'hFFFF) :
                            $urandom_range(32'h10000, 32'h10FFFF);
          queue_utf8(cp);
        end else if (kind <= 6) begin
          cls = $urandom_range(0, 2);
          cp = (cls == 0) ? $urandom_range(0, 32'hD7FF) :
               (cls == 1) ? $urandom_range(32'hE000, 32'hFFFF) :
                            $urandom_range(32'h10000, 32'h10FFFF);
          queue_utf16(cp, kind != 6);
        end else begin
          cp = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h10FFFF);
          queue_word32(cp, kind == 7);
        end
      end
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_hs) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (byte_q.size() == 0 || (byte_q[0].drain && expected_cps.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= byte_q[0].data;
        s_axis_tuser <= byte_q[0].sos;
        if (burst_left == 0)
          burst_left = $urandom_range(1, 16);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!held_once && bytes_taken >= 60) begin
      held_once = 1'b1;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_phase / 64) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        2: m_axis_tready <= (rx_phase % 4 != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // checker and predictor
  always @(posedge clk) begin : check_and_predict
    cp_rec_t want;
    if (rst) begin
      in_hs = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cps.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected item: cp %h enc %0d last %b",
                     m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_cps.pop_front();
          if (m_axis_tdata[31:0] !== want.cp || m_axis_tdata[34:32] !== want.enc ||
              m_axis_tlast !== want.last) begin
            if (mismatches < 10)
              $display("mismatch: cp exp %h got %h, enc exp %0d got %0d, last exp %b got %b",
                       want.cp, m_axis_tdata[31:0], want.enc, m_axis_tdata[34:32],
                       want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      in_hs = s_axis_tvalid && s_axis_tready;
      if (in_hs) begin
        absorb_byte(s_axis_tdata, s_axis_tuser);
        void'(byte_q.pop_front());
        bytes_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int base;
    bit drain_done;
    drain_done = 1'b0;

    // utf32be mark, then all-ones word
    sos_next = 1'b1;
    queue_word(32'h0000FEFF);
    queue_word(32'hFFFFFFFF);
    // utf32le mark alone, sent after everything so far has come out
    drain_next = 1'b1;
    sos_next = 1'b1;
    queue_word(32'hFFFE0000);
    // utf16le, lone trailing unit taken as lead, then combined with plain unit
    sos_next = 1'b1;
    queue_word(32'hFFFE00DC);
    queue_byte(8'h41);
    queue_byte(8'h00);
    // utf16be with pending lead, dropped by a short stream restart
    sos_next = 1'b1;
    queue_word(32'hFEFFD800);
    sos_next = 1'b1;
    queue_byte(8'hAA);
    queue_byte(8'hBB);
    // utf8 with unchecked continuations, bad leads and ascii edge
    sos_next = 1'b1;
    queue_word(32'hF0807FF8);
    queue_word(32'hFF807FC3);
    queue_byte(8'hA9);

    base = byte_q.size();
    while (byte_q.size() - base < RANDOM_BYTES) begin
      if (!drain_done && byte_q.size() - base > RANDOM_BYTES / 2) begin
        drain_next = 1'b1;
        drain_done = 1'b1;
      end
      queue_stream();
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0) @(posedge clk);
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
